// ----- design/tpt_pkg.sv -----
package tpt_pkg;

    // Request codes carried in s_axis_tuser
    typedef enum logic [2:0] {
        REQ_PAIR       = 3'd0,
        REQ_FIND_TOKEN = 3'd1,
        REQ_FIND_ID    = 3'd2,
        REQ_REMOVE     = 3'd3,
        REQ_SET_ENABLE = 3'd4,
        REQ_CLEAR      = 3'd5,
        REQ_COUNT      = 3'd6,
        REQ_SLOT_ID    = 3'd7
    } req_t;

    // What the compare unit looks for in a slot
    typedef enum logic [1:0] {
        MATCH_NONE,
        MATCH_TOKEN,
        MATCH_ID,
        MATCH_ANY
    } match_mode_t;

    // One table entry as kept in the entry RAM
    typedef struct packed {
        logic [3:0]  color;
        logic [31:0] token;
        logic [7:0]  id;
    } entry_t;

    // Search key presented to the compare unit
    typedef struct packed {
        logic [31:0] token;
        logic [7:0]  id;
    } key_t;

    // Slave-side tdata layout, lowest field last
    typedef struct packed {
        logic [6:0]  pad;
        logic [7:0]  slot;
        logic        enable;
        logic [7:0]  id;
        logic [31:0] token;
    } in_word_t;

    // Master-side tdata layout, lowest field last
    typedef struct packed {
        logic [2:0]  pad;
        logic [7:0]  count;
        logic        enabled;
        logic [3:0]  color;
        logic [31:0] token;
        logic [7:0]  slot;
        logic [7:0]  id;
    } out_word_t;

    localparam int IN_DATA_W  = $bits(in_word_t);
    localparam int OUT_DATA_W = $bits(out_word_t);
    localparam int ENTRY_W    = $bits(entry_t);

    localparam logic [7:0] NO_ID      = 8'hFF;
    localparam logic [7:0] FIRST_ID   = 8'd1;
    localparam logic [3:0] COLOR_LAST = 4'd9;

endpackage

// ----- design/tpt_ram.sv -----
module tpt_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/tpt_match.sv -----
module tpt_match (
    input  tpt_pkg::match_mode_t mode,
    input  tpt_pkg::key_t        key,
    input  tpt_pkg::entry_t      entry,
    input  logic                 entry_valid,
    output logic                 hit
);

    // Shared slot comparator; a free slot never matches
    always_comb
    begin
        unique case (mode)
            tpt_pkg::MATCH_TOKEN: hit = entry_valid && (entry.token == key.token);
            tpt_pkg::MATCH_ID:    hit = entry_valid && (entry.id == key.id);
            tpt_pkg::MATCH_ANY:   hit = entry_valid;
            default:              hit = 1'b0;
        endcase
    end

endmodule

// ----- design/token_pairing_table.sv -----
// Channel   Dir  tdata                                      tuser
// s_axis    in   token_in, id_in, enable_in, slot_in        req_type
// m_axis    out  id, slot, token, color, enabled, count     found
//
// One request at a time: slots are read from the entry RAM one per cycle
// into a single comparator, and a hit ends the walk. A new request can be
// taken in the same cycle that tvalid rises. Reset empties the table at
// once. A finished result waits in the output register while the next
// request is accepted; a stalled m_axis holds only the response step.
module token_pairing_table #(
    parameter int TABLE_SLOTS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] token_in, [39:32] id_in, [40] enable_in, [48:41] slot_in
    input  logic [tpt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [2:0] req_type
    input  logic [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] id_out, [15:8] slot_out, [47:16] token_out, [51:48] color_out,
    // [52] enabled_out, [60:53] paired_count
    output logic [tpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] found
    output logic                             m_axis_tuser
);

    localparam int         IDX_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [7:0] SLOTS_8  = 8'(TABLE_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t                 state_reg, state_next;
    tpt_pkg::req_t          req_reg, req_next;
    tpt_pkg::match_mode_t   mode_reg, mode_next;
    tpt_pkg::key_t          key_reg, key_next;
    logic                   en_reg, en_next;

    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]       rd_end_reg, rd_end_next;
    logic [3:0]             rd_color_reg, rd_color_next;
    logic                   rd_active_reg, rd_active_next;

    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [3:0]             cmp_color_reg, cmp_color_next;
    logic                   cmp_last_reg, cmp_last_next;

    logic [7:0]             cnt_reg, cnt_next;
    logic                   free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [3:0]             free_color_reg, free_color_next;

    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    tpt_pkg::entry_t        hit_entry_reg, hit_entry_next;

    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [TABLE_SLOTS-1:0] enabled_reg, enabled_next;
    logic [7:0]             next_id_reg, next_id_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_user_reg, m_user_next;
    tpt_pkg::out_word_t     m_data_reg, m_data_next;

    tpt_pkg::in_word_t      in_word;
    tpt_pkg::out_word_t     out_word;
    logic                   out_found;

    logic                   ram_wr_en;
    tpt_pkg::entry_t        ram_wr_data;
    logic                   ram_rd_en;
    logic [tpt_pkg::ENTRY_W-1:0] ram_rd_raw;
    tpt_pkg::entry_t        ram_rd_data;
    logic                   cmp_hit;

    assign in_word     = tpt_pkg::in_word_t'(s_axis_tdata);
    assign ram_rd_data = tpt_pkg::entry_t'(ram_rd_raw);

    // Entry storage: id, token and color per slot
    tpt_ram #(
        .WIDTH (tpt_pkg::ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_raw)
    );

    // Shared comparator on the slot coming out of the RAM
    tpt_match u_match (
        .mode        (mode_reg),
        .key         (key_reg),
        .entry       (ram_rd_data),
        .entry_valid (valid_reg[cmp_idx_reg]),
        .hit         (cmp_hit)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        en_next         = en_reg;
        rd_idx_next     = rd_idx_reg;
        rd_end_next     = rd_end_reg;
        rd_color_next   = rd_color_reg;
        rd_active_next  = rd_active_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        cmp_color_next  = cmp_color_reg;
        cmp_last_next   = cmp_last_reg;
        cnt_next        = cnt_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        free_color_next = free_color_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_entry_next  = hit_entry_reg;
        valid_next      = valid_reg;
        enabled_next    = enabled_reg;
        next_id_next    = next_id_reg;
        m_valid_next    = m_valid_reg;
        m_user_next     = m_user_reg;
        m_data_next     = m_data_reg;

        ram_wr_en   = 1'b0;
        ram_wr_data = '{color: free_color_reg, token: key_reg.token, id: next_id_reg};
        ram_rd_en   = 1'b0;

        out_word    = '0;
        out_word.id = tpt_pkg::NO_ID;
        out_found   = 1'b0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next        = tpt_pkg::req_t'(s_axis_tuser);
                    key_next.token  = in_word.token;
                    key_next.id     = in_word.id;
                    en_next         = in_word.enable;
                    rd_idx_next     = '0;
                    rd_end_next     = LAST_IDX;
                    rd_color_next   = '0;
                    rd_active_next  = 1'b1;
                    cnt_next        = '0;
                    free_vld_next   = 1'b0;
                    hit_next        = 1'b0;
                    state_next      = ST_SCAN;
                    unique case (tpt_pkg::req_t'(s_axis_tuser)) inside
                        tpt_pkg::REQ_PAIR, tpt_pkg::REQ_FIND_TOKEN:
                        begin
                            mode_next = tpt_pkg::MATCH_TOKEN;
                        end
                        tpt_pkg::REQ_FIND_ID, tpt_pkg::REQ_REMOVE,
                        tpt_pkg::REQ_SET_ENABLE:
                        begin
                            mode_next = tpt_pkg::MATCH_ID;
                        end
                        tpt_pkg::REQ_COUNT:
                        begin
                            mode_next = tpt_pkg::MATCH_NONE;
                        end
                        tpt_pkg::REQ_SLOT_ID:
                        begin
                            mode_next   = tpt_pkg::MATCH_ANY;
                            rd_idx_next = in_word.slot[IDX_W-1:0];
                            rd_end_next = in_word.slot[IDX_W-1:0];
                            if (in_word.slot >= SLOTS_8)
                            begin
                                rd_active_next = 1'b0;
                                state_next     = ST_RESP;
                            end
                        end
                        default:
                        begin
                            // clear needs no scan
                            mode_next      = tpt_pkg::MATCH_NONE;
                            rd_active_next = 1'b0;
                            state_next     = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Read issue, one slot per cycle
                if (rd_active_reg)
                begin
                    ram_rd_en      = 1'b1;
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = rd_idx_reg;
                    cmp_color_next = rd_color_reg;
                    cmp_last_next  = (rd_idx_reg == rd_end_reg);
                    if (rd_idx_reg == rd_end_reg)
                    begin
                        rd_active_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next   = rd_idx_reg + 1'b1;
                        rd_color_next = (rd_color_reg == tpt_pkg::COLOR_LAST) ?
                                        4'd0 : rd_color_reg + 4'd1;
                    end
                end

                // Compare stage on the registered RAM data
                if (cmp_vld_reg)
                begin
                    if (valid_reg[cmp_idx_reg])
                    begin
                        cnt_next = cnt_reg + 8'd1;
                    end
                    else if (!free_vld_reg)
                    begin
                        free_vld_next   = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                        free_color_next = cmp_color_reg;
                    end
                    if (cmp_hit)
                    begin
                        hit_next       = 1'b1;
                        hit_idx_next   = cmp_idx_reg;
                        hit_entry_next = ram_rd_data;
                        rd_active_next = 1'b0;
                        cmp_vld_next   = 1'b0;
                        state_next     = ST_RESP;
                    end
                    else if (cmp_last_reg)
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    if (hit_reg)
                    begin
                        out_found        = 1'b1;
                        out_word.id      = hit_entry_reg.id;
                        out_word.slot    = 8'(hit_idx_reg);
                        out_word.token   = hit_entry_reg.token;
                        out_word.color   = hit_entry_reg.color;
                        out_word.enabled = enabled_reg[hit_idx_reg];
                    end

                    unique case (req_reg)
                        tpt_pkg::REQ_PAIR:
                        begin
                            // new token: take the first free slot if ids remain
                            if (!hit_reg && free_vld_reg && (next_id_reg <= SLOTS_8))
                            begin
                                ram_wr_en                  = 1'b1;
                                valid_next[free_idx_reg]   = 1'b1;
                                next_id_next               = next_id_reg + 8'd1;
                                out_found                  = 1'b1;
                                out_word.id                = next_id_reg;
                                out_word.slot              = 8'(free_idx_reg);
                                out_word.token             = key_reg.token;
                                out_word.color             = free_color_reg;
                                out_word.enabled           = enabled_reg[free_idx_reg];
                            end
                        end
                        tpt_pkg::REQ_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                valid_next[hit_idx_reg]   = 1'b0;
                                enabled_next[hit_idx_reg] = 1'b1;
                            end
                        end
                        tpt_pkg::REQ_SET_ENABLE:
                        begin
                            if (hit_reg)
                            begin
                                enabled_next[hit_idx_reg] = en_reg;
                                out_word.enabled          = en_reg;
                            end
                        end
                        tpt_pkg::REQ_CLEAR:
                        begin
                            out_found    = 1'b1;
                            valid_next   = '0;
                            enabled_next = '1;
                            next_id_next = tpt_pkg::FIRST_ID;
                        end
                        tpt_pkg::REQ_COUNT:
                        begin
                            out_found      = 1'b1;
                            out_word.count = cnt_reg;
                        end
                        default:
                        begin
                            // lookups report the hit as latched
                        end
                    endcase

                    m_valid_next = 1'b1;
                    m_user_next  = out_found;
                    m_data_next  = out_word;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_reg        <= tpt_pkg::REQ_PAIR;
            mode_reg       <= tpt_pkg::MATCH_NONE;
            key_reg        <= '0;
            en_reg         <= 1'b0;
            rd_idx_reg     <= '0;
            rd_end_reg     <= '0;
            rd_color_reg   <= '0;
            rd_active_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            cmp_color_reg  <= '0;
            cmp_last_reg   <= 1'b0;
            cnt_reg        <= '0;
            free_vld_reg   <= 1'b0;
            free_idx_reg   <= '0;
            free_color_reg <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_entry_reg  <= '0;
            valid_reg      <= '0;
            enabled_reg    <= '1;
            next_id_reg    <= tpt_pkg::FIRST_ID;
            m_valid_reg    <= 1'b0;
            m_user_reg     <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            mode_reg       <= mode_next;
            key_reg        <= key_next;
            en_reg         <= en_next;
            rd_idx_reg     <= rd_idx_next;
            rd_end_reg     <= rd_end_next;
            rd_color_reg   <= rd_color_next;
            rd_active_reg  <= rd_active_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            cmp_color_reg  <= cmp_color_next;
            cmp_last_reg   <= cmp_last_next;
            cnt_reg        <= cnt_next;
            free_vld_reg   <= free_vld_next;
            free_idx_reg   <= free_idx_next;
            free_color_reg <= free_color_next;
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            hit_entry_reg  <= hit_entry_next;
            valid_reg      <= valid_next;
            enabled_reg    <= enabled_next;
            next_id_reg    <= next_id_next;
            m_valid_reg    <= m_valid_next;
            m_user_reg     <= m_user_next;
            m_data_reg     <= m_data_next;
        end
    end

endmodule

// ----- design/tpt_checker.sv -----
module tpt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [tpt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);

    // Stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One request in flight: ready drops right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // A miss reports the empty entry
    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata[7:0] == 8'hFF) && (m_axis_tdata[47:16] == 32'd0)
            && (m_axis_tdata[60:53] == 8'd0))
        else $error("miss with entry fields set");

    // Colors stay in the ten-entry cycle
    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[51:48] <= 4'd9))
        else $error("color index out of range");

endmodule

bind token_pairing_table tpt_checker u_tpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/tb.sv -----
module tb;

    localparam int SLOTS       = 8;
    localparam int COLOR_WRAP  = 10;
    localparam int IDLE_PCT    = 21;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 50;
    localparam int RANDOM_ITEMS = 350;

    // One expected response, field by field
    typedef struct packed {
        logic        found;
        logic [7:0]  id;
        logic [7:0]  slot;
        logic [31:0] token;
        logic [3:0]  color;
        logic        enabled;
        logic [7:0]  count;
    } table_response_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [tpt_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [2:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [tpt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;

    // Shadow copy of the pairing table
    logic        tbl_used    [SLOTS];
    logic [7:0]  tbl_id      [SLOTS];
    logic [31:0] tbl_token   [SLOTS];
    logic [3:0]  tbl_color   [SLOTS];
    logic        tbl_enabled [SLOTS];
    int          id_counter;

    table_response_t pending_responses[$];
    int              error_count = 0;
    int              cycle_count = 0;
    logic            no_idle;

    token_pairing_table #(
        .TABLE_SLOTS(SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void clear_table();
        for (int s = 0; s < SLOTS; s++)
        begin
            tbl_used[s]    = 1'b0;
            tbl_id[s]      = '0;
            tbl_token[s]   = '0;
            tbl_color[s]   = '0;
            tbl_enabled[s] = 1'b1;
        end
        id_counter = 1;
    endfunction

    function automatic table_response_t miss_response(input logic hit, input logic [7:0] cnt);
        table_response_t r;
        r = '0;
        r.found = hit;
        r.id    = tpt_pkg::NO_ID;
        r.count = cnt;
        return r;
    endfunction

    function automatic table_response_t entry_response(input int s);
        table_response_t r;
        r = '0;
        r.found   = 1'b1;
        r.id      = tbl_id[s];
        r.slot    = s[7:0];
        r.token   = tbl_token[s];
        r.color   = tbl_color[s];
        r.enabled = tbl_enabled[s];
        return r;
    endfunction

    // Only occupied slots take part in a search
    function automatic int slot_of_token(input logic [31:0] tok);
        for (int s = 0; s < SLOTS; s++)
            if (tbl_used[s] && tbl_token[s] == tok)
                return s;
        return -1;
    endfunction

    function automatic int slot_of_id(input logic [7:0] id);
        for (int s = 0; s < SLOTS; s++)
            if (tbl_used[s] && tbl_id[s] == id)
                return s;
        return -1;
    endfunction

    // Works out the response to one request and updates the shadow table
    function automatic table_response_t predict_response(input tpt_pkg::req_t kind,
        input logic [31:0] tok, input logic [7:0] id, input logic en, input logic [7:0] slot);
        table_response_t r;
        int              s;
        int              cnt;
        r = miss_response(1'b0, '0);
        case (kind)
            tpt_pkg::REQ_PAIR:
            begin
                s = slot_of_token(tok);
                if (s >= 0)
                    r = entry_response(s);
                else if (id_counter <= SLOTS)
                begin
                    s = 0;
                    while (s < SLOTS && tbl_used[s])
                        s++;
                    if (s < SLOTS)
                    begin
                        tbl_used[s]  = 1'b1;
                        tbl_id[s]    = id_counter[7:0];
                        tbl_token[s] = tok;
                        tbl_color[s] = 4'(s % COLOR_WRAP);
                        id_counter++;
                        r = entry_response(s);
                    end
                end
            end
            tpt_pkg::REQ_FIND_TOKEN:
            begin
                s = slot_of_token(tok);
                if (s >= 0)
                    r = entry_response(s);
            end
            tpt_pkg::REQ_FIND_ID:
            begin
                s = slot_of_id(id);
                if (s >= 0)
                    r = entry_response(s);
            end
            tpt_pkg::REQ_REMOVE:
            begin
                // report the entry as it was, then free the slot
                s = slot_of_id(id);
                if (s >= 0)
                begin
                    r = entry_response(s);
                    tbl_used[s]    = 1'b0;
                    tbl_enabled[s] = 1'b1;
                end
            end
            tpt_pkg::REQ_SET_ENABLE:
            begin
                s = slot_of_id(id);
                if (s >= 0)
                begin
                    tbl_enabled[s] = en;
                    r = entry_response(s);
                end
            end
            tpt_pkg::REQ_CLEAR:
            begin
                clear_table();
                r = miss_response(1'b1, '0);
            end
            tpt_pkg::REQ_COUNT:
            begin
                cnt = 0;
                for (int k = 0; k < SLOTS; k++)
                    if (tbl_used[k])
                        cnt++;
                r = miss_response(1'b1, cnt[7:0]);
            end
            tpt_pkg::REQ_SLOT_ID:
            begin
                if (slot < SLOTS && tbl_used[slot])
                    r = entry_response(int'(slot));
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_REPORTS)
            $display("mismatch %s: got %0h, expected %0h (cycle %0d)",
                     what, got, want, cycle_count);
        error_count++;
    endtask

    // Prediction on every accepted request transaction
    always @(posedge clk)
    begin : predict_accepted
        tpt_pkg::in_word_t w;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            w = s_axis_tdata;
            pending_responses.push_back(predict_response(tpt_pkg::req_t'(s_axis_tuser),
                w.token, w.id, w.enable, w.slot));
        end
    end

    // Compare every response transaction with the oldest expectation
    always @(posedge clk)
    begin : check_response
        tpt_pkg::out_word_t w;
        table_response_t    want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            w = m_axis_tdata;
            if (pending_responses.size() == 0)
                report_mismatch("unexpected response, id", w.id, tpt_pkg::NO_ID);
            else
            begin
                want = pending_responses.pop_front();
                if (m_axis_tuser !== want.found)
                    report_mismatch("found", m_axis_tuser, want.found);
                if (w.id !== want.id)
                    report_mismatch("id", w.id, want.id);
                if (w.slot !== want.slot)
                    report_mismatch("slot", w.slot, want.slot);
                if (w.token !== want.token)
                    report_mismatch("token", w.token, want.token);
                if (w.color !== want.color)
                    report_mismatch("color", w.color, want.color);
                if (w.enabled !== want.enabled)
                    report_mismatch("enabled", w.enabled, want.enabled);
                if (w.count !== want.count)
                    report_mismatch("count", w.count, want.count);
            end
        end
    end

    // Response side backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Sends one request; tvalid stays high on return so back-to-back requests flow
    task automatic send_request(input tpt_pkg::req_t kind, input logic [31:0] tok,
                                input logic [7:0] id, input logic en, input logic [7:0] slot);
        tpt_pkg::in_word_t w;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        w = '0;
        w.token  = tok;
        w.id     = id;
        w.enable = en;
        w.slot   = slot;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Holds off the sender until every expected response has come back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_responses.size() != 0);
    endtask

    // Extremes of every field and the no-entry cases
    task automatic test_directed();
        send_request(tpt_pkg::REQ_COUNT,      32'h0,        8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_FIND_TOKEN, 32'h0,        8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_FIND_ID,    32'h0,        tpt_pkg::NO_ID, 1'b1, 8'd0);
        send_request(tpt_pkg::REQ_FIND_ID,    32'h0,        8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_SLOT_ID,    32'h0,        8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_SLOT_ID,    32'hFFFFFFFF, 8'd0,   1'b0, 8'd255);
        send_request(tpt_pkg::REQ_PAIR,       32'h0,        8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_PAIR,       32'hFFFFFFFF, 8'd255, 1'b1, 8'd255);
        send_request(tpt_pkg::REQ_PAIR,       32'h0,        8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_FIND_TOKEN, 32'hFFFFFFFF, 8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_FIND_ID,    32'h0,        8'd2,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_SET_ENABLE, 32'h0,        8'd2,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_SLOT_ID,    32'h0,        8'd0,   1'b0, 8'd1);
        send_request(tpt_pkg::REQ_SLOT_ID,    32'h0,        8'd0,   1'b0, 8'(SLOTS));
        send_request(tpt_pkg::REQ_REMOVE,     32'h0,        8'd1,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_REMOVE,     32'h0,        8'd1,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_FIND_TOKEN, 32'h0,        8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_PAIR,       32'h12345678, 8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_SET_ENABLE, 32'h0,        tpt_pkg::NO_ID, 1'b1, 8'd0);
        send_request(tpt_pkg::REQ_REMOVE,     32'h0,        tpt_pkg::NO_ID, 1'b0, 8'd0);
        send_request(tpt_pkg::REQ_SET_ENABLE, 32'h0,        8'd2,   1'b1, 8'd0);
        send_request(tpt_pkg::REQ_COUNT,      32'h0,        8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_CLEAR,      32'h0,        8'd0,   1'b0, 8'd0);
        send_request(tpt_pkg::REQ_COUNT,      32'h0,        8'd0,   1'b0, 8'd0);
    endtask

    // Fill the table, run the id counter out, then recover with a clear
    task automatic test_exhaustion();
        logic [31:0] base;
        base = $urandom();
        send_request(tpt_pkg::REQ_CLEAR, 32'h0, 8'd0, 1'b0, 8'd0);
        for (int k = 0; k < SLOTS; k++)
            send_request(tpt_pkg::REQ_PAIR, base + k, 8'd0, 1'b0, 8'd0);
        send_request(tpt_pkg::REQ_PAIR, base + 100, 8'd0, 1'b0, 8'd0);
        send_request(tpt_pkg::REQ_PAIR, base, 8'd0, 1'b0, 8'd0);
        send_request(tpt_pkg::REQ_REMOVE, 32'h0, 8'd3, 1'b0, 8'd0);
        // free slot exists but the id counter is spent
        send_request(tpt_pkg::REQ_PAIR, base + 100, 8'd0, 1'b0, 8'd0);
        send_request(tpt_pkg::REQ_SET_ENABLE, 32'h0, 8'd5, 1'b0, 8'd0);
        for (int k = 0; k < SLOTS; k++)
            send_request(tpt_pkg::REQ_SLOT_ID, 32'h0, 8'd0, 1'b0, k[7:0]);
        send_request(tpt_pkg::REQ_COUNT, 32'h0, 8'd0, 1'b0, 8'd0);
        send_request(tpt_pkg::REQ_CLEAR, 32'h0, 8'd0, 1'b0, 8'd0);
        send_request(tpt_pkg::REQ_PAIR, base + 100, 8'd0, 1'b0, 8'd0);
    endtask

    // Mostly live tokens and small ids so requests hit, with some wide noise
    task automatic test_random_traffic();
        logic [31:0]   known_tokens[12];
        logic [31:0]   tok;
        logic [7:0]    id;
        logic [7:0]    slot;
        logic          en;
        int            pick;
        tpt_pkg::req_t kind;
        foreach (known_tokens[k])
            known_tokens[k] = $urandom();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 120 && n < 200);
            if (n == 260)
                hold_until_drained();
            tok  = ($urandom_range(99) < 80) ? known_tokens[$urandom_range(11)] : $urandom();
            id   = ($urandom_range(99) < 85) ? 8'($urandom_range(SLOTS + 1))
                                             : 8'($urandom_range(255));
            slot = ($urandom_range(99) < 85) ? 8'($urandom_range(SLOTS))
                                             : 8'($urandom_range(255));
            en   = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 30)
                kind = tpt_pkg::REQ_PAIR;
            else if (pick < 45)
                kind = tpt_pkg::REQ_FIND_TOKEN;
            else if (pick < 58)
                kind = tpt_pkg::REQ_FIND_ID;
            else if (pick < 70)
                kind = tpt_pkg::REQ_REMOVE;
            else if (pick < 82)
                kind = tpt_pkg::REQ_SET_ENABLE;
            else if (pick < 86)
                kind = tpt_pkg::REQ_CLEAR;
            else if (pick < 92)
                kind = tpt_pkg::REQ_COUNT;
            else
                kind = tpt_pkg::REQ_SLOT_ID;
            send_request(kind, tok, id, en, slot);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tpt_pkg::REQ_PAIR;
        m_axis_tready = 1'b0;
        no_idle       = 1'b0;
        clear_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_exhaustion();
        test_random_traffic();

        hold_until_drained();
        repeat (4 * (SLOTS + 3)) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
